[rtl/qrs_pkg.sv]
// quadratic root solver: shared types, widths and codes
// no dependencies; used by every rtl file
`timescale 1ns / 1ps

package qrs_pkg;

    localparam int COEF_W  = 32;
    localparam int CY_W    = 33;
    localparam int PROD_W  = 65;
    localparam int DELTA_W = 69;
    localparam int ROOT_W  = 35;
    localparam int TRIAL_W = 71;
    localparam int NUM_W   = 37;
    localparam int MAG_W   = 36;
    localparam int DEN_W   = 34;
    localparam int IDX_W   = 2;
    localparam int CNT_W   = 2;

    typedef enum logic [IDX_W-1:0] {
        REG_A = 2'd0,
        REG_B = 2'd1,
        REG_C = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_LINE = 2'd1,
        MODE_ONE  = 2'd2,
        MODE_TWO  = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t                  mode;
        logic signed [CY_W-1:0] cy;
    } sq_pay_t;

    typedef struct packed {
        mode_t mode;
        logic  neg;
    } dv_pay_t;

endpackage

[rtl/qrs_sqrt_cell.sv]
// one digit of the pipelined floor square root of the discriminant
// depends on qrs_pkg
`timescale 1ns / 1ps

module qrs_sqrt_cell #(
    parameter int K = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          valid_i,
    input  logic [qrs_pkg::DELTA_W-1:0]   rem_i,
    input  logic [qrs_pkg::ROOT_W-1:0]    root_i,
    input  qrs_pkg::sq_pay_t              pay_i,
    output logic                          valid_o,
    output logic [qrs_pkg::DELTA_W-1:0]   rem_o,
    output logic [qrs_pkg::ROOT_W-1:0]    root_o,
    output qrs_pkg::sq_pay_t              pay_o
);
    import qrs_pkg::*;

    logic                 valid_reg;
    logic [DELTA_W-1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]    root_reg, root_next;
    sq_pay_t              pay_reg;
    logic [TRIAL_W-1:0]   trial;
    logic                 ge;

    always_comb
    begin
        trial = (TRIAL_W'(root_i) << (K + 1)) | (TRIAL_W'(1) << (2 * K));
        ge = TRIAL_W'(rem_i) >= trial;
        rem_next = ge ? rem_i - trial[DELTA_W-1:0] : rem_i;
        root_next = ge ? (root_i | (ROOT_W'(1) << K)) : root_i;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            pay_reg  <= pay_i;
        end
    end

    assign valid_o = valid_reg;
    assign rem_o   = rem_reg;
    assign root_o  = root_reg;
    assign pay_o   = pay_reg;

endmodule

[rtl/qrs_div_cell.sv]
// one quotient bit of the pipelined restoring divider
// depends on qrs_pkg
`timescale 1ns / 1ps

module qrs_div_cell #(
    parameter int QW = 52
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        valid_i,
    input  logic [qrs_pkg::DEN_W-1:0]   rem_i,
    input  logic [QW-1:0]               dq_i,
    input  logic [qrs_pkg::DEN_W-1:0]   den_i,
    input  qrs_pkg::dv_pay_t            pay_i,
    output logic                        valid_o,
    output logic [qrs_pkg::DEN_W-1:0]   rem_o,
    output logic [QW-1:0]               dq_o,
    output logic [qrs_pkg::DEN_W-1:0]   den_o,
    output qrs_pkg::dv_pay_t            pay_o
);
    import qrs_pkg::*;

    logic               valid_reg;
    logic [DEN_W-1:0]   rem_reg, rem_next;
    logic [QW-1:0]      dq_reg, dq_next;
    logic [DEN_W-1:0]   den_reg;
    dv_pay_t            pay_reg;
    logic [DEN_W-1:0]   rem_sh;
    logic               ge;

    always_comb
    begin
        rem_sh   = {rem_i[DEN_W-2:0], dq_i[QW-1]};
        ge       = rem_sh >= den_i;
        rem_next = ge ? rem_sh - den_i : rem_sh;
        dq_next  = {dq_i[QW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
            den_reg <= den_i;
            pay_reg <= pay_i;
        end
    end

    assign valid_o = valid_reg;
    assign rem_o   = rem_reg;
    assign dq_o    = dq_reg;
    assign den_o   = den_reg;
    assign pay_o   = pay_reg;

endmodule

[rtl/quadratic_root_solver_top.sv]
// quadratic root solver top: coefficient registers, discriminant, sqrt and divider chains
// depends on qrs_pkg, qrs_sqrt_cell, qrs_div_cell
//
// channel   signals                         direction  meaning
// config    cfg_valid/cfg_ready/index/data  in         coefficient write, always ready
// request   y_valid/y_stall/y_value         in         target value y
// result    root_valid/root_stall/fields    out        root count, roots, clamp flag
//
// stages: c - y, products, discriminant, sqrt cells, operand prep, divider cells, output reg
// one request per cycle is taken; the pipeline holds as a whole while a result waits stalled
// reset clears coefficients and all valid bits; no clearing pass
`timescale 1ns / 1ps

module quadratic_root_solver_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [qrs_pkg::IDX_W-1:0]           cfg_index,
    input  logic [qrs_pkg::COEF_W-1:0]          cfg_data,
    input  logic                                y_valid,
    output logic                                y_stall,
    input  logic signed [qrs_pkg::COEF_W-1:0]   y_value,
    output logic                                root_valid,
    input  logic                                root_stall,
    output logic [qrs_pkg::CNT_W-1:0]           root_count,
    output logic signed [qrs_pkg::COEF_W-1:0]   root_first,
    output logic signed [qrs_pkg::COEF_W-1:0]   root_second,
    output logic                                saturated
);
    import qrs_pkg::*;

    localparam int QW = MAG_W + FRAC_BITS;

    logic signed [COEF_W-1:0] coef_a_reg, coef_b_reg, coef_c_reg;
    logic adv;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg <= '0;
            coef_b_reg <= '0;
            coef_c_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_A:   coef_a_reg <= cfg_data;
                REG_B:   coef_b_reg <= cfg_data;
                REG_C:   coef_c_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: c - y
    logic                   s1_valid_reg;
    logic signed [CY_W-1:0] cy_reg;

    // stage 2: products
    logic                   s2_valid_reg;
    logic [2*COEF_W-1:0]    b2_reg;
    logic [PROD_W-1:0]      t_reg;
    logic                   tneg_reg, cyz_reg;
    logic signed [CY_W-1:0] cy2_reg;

    // stage 3: discriminant
    logic                   s3_valid_reg;
    logic [DELTA_W-1:0]     delta_reg, delta_next;
    mode_t                  mode_reg, mode_next;
    logic signed [CY_W-1:0] cy3_reg;

    logic [COEF_W-1:0] amag, bmag;
    logic [CY_W-1:0]   cymag;
    logic [DELTA_W-1:0] b2x, t4x;

    always_comb
    begin
        amag  = coef_a_reg[COEF_W-1] ? COEF_W'(0) - coef_a_reg : coef_a_reg;
        bmag  = coef_b_reg[COEF_W-1] ? COEF_W'(0) - coef_b_reg : coef_b_reg;
        cymag = cy_reg[CY_W-1] ? CY_W'(0) - cy_reg : cy_reg;
        b2x   = DELTA_W'(b2_reg);
        t4x   = DELTA_W'({t_reg, 2'b00});
        delta_next = '0;
        mode_next  = MODE_NONE;
        if (coef_a_reg == '0)
        begin
            mode_next = (coef_b_reg != '0) ? MODE_LINE : MODE_NONE;
        end
        else if (tneg_reg || cyz_reg)
        begin
            mode_next  = MODE_TWO;
            delta_next = b2x + t4x;
        end
        else if (b2x >= t4x)
        begin
            mode_next  = MODE_TWO;
            delta_next = b2x - t4x;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= y_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cy_reg    <= CY_W'(coef_c_reg) - CY_W'(y_value);
            b2_reg    <= bmag * bmag;
            t_reg     <= PROD_W'(amag) * PROD_W'(cymag);
            tneg_reg  <= coef_a_reg[COEF_W-1] ^ cy_reg[CY_W-1];
            cyz_reg   <= cy_reg == '0;
            cy2_reg   <= cy_reg;
            delta_reg <= delta_next;
            mode_reg  <= mode_next;
            cy3_reg   <= cy2_reg;
        end
    end

    // square root chain
    logic               sq_valid [0:ROOT_W];
    logic [DELTA_W-1:0] sq_rem   [0:ROOT_W];
    logic [ROOT_W-1:0]  sq_root  [0:ROOT_W];
    sq_pay_t            sq_pay   [0:ROOT_W];

    assign sq_valid[0]     = s3_valid_reg;
    assign sq_rem[0]       = delta_reg;
    assign sq_root[0]      = '0;
    assign sq_pay[0].mode  = mode_reg;
    assign sq_pay[0].cy    = cy3_reg;

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_sqrt
        qrs_sqrt_cell #(
            .K (ROOT_W - 1 - i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .valid_i (sq_valid[i]),
            .rem_i   (sq_rem[i]),
            .root_i  (sq_root[i]),
            .pay_i   (sq_pay[i]),
            .valid_o (sq_valid[i+1]),
            .rem_o   (sq_rem[i+1]),
            .root_o  (sq_root[i+1]),
            .pay_o   (sq_pay[i+1])
        );
    end

    // operand preparation
    logic                    pr_valid_reg;
    logic [QW-1:0]           pr_dq1_reg, pr_dq2_reg;
    logic [DEN_W-1:0]        pr_den_reg;
    dv_pay_t                 pr_pay1_reg, pr_pay2_reg;

    logic signed [NUM_W-1:0] nb, sx, n1, n2;
    logic signed [DEN_W-1:0] den;
    logic [NUM_W-1:0]        n1m, n2m;
    logic [DEN_W-1:0]        denm;
    mode_t                   pmode;

    always_comb
    begin
        nb = NUM_W'(0) - NUM_W'(coef_b_reg);
        sx = NUM_W'(sq_root[ROOT_W]);
        pmode = sq_pay[ROOT_W].mode;
        if (pmode == MODE_LINE)
        begin
            n1  = NUM_W'(0) - NUM_W'(sq_pay[ROOT_W].cy);
            n2  = '0;
            den = DEN_W'(coef_b_reg);
        end
        else
        begin
            n1  = nb + sx;
            n2  = nb - sx;
            den = DEN_W'(coef_a_reg) <<< 1;
            if (pmode == MODE_TWO && sq_root[ROOT_W] == '0)
            begin
                pmode = MODE_ONE;
            end
        end
        n1m  = n1[NUM_W-1] ? NUM_W'(0) - n1 : n1;
        n2m  = n2[NUM_W-1] ? NUM_W'(0) - n2 : n2;
        denm = den[DEN_W-1] ? DEN_W'(0) - den : den;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pr_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            pr_valid_reg <= sq_valid[ROOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pr_dq1_reg       <= {n1m[MAG_W-1:0], {FRAC_BITS{1'b0}}};
            pr_dq2_reg       <= {n2m[MAG_W-1:0], {FRAC_BITS{1'b0}}};
            pr_den_reg       <= denm;
            pr_pay1_reg.mode <= pmode;
            pr_pay1_reg.neg  <= n1[NUM_W-1] ^ den[DEN_W-1];
            pr_pay2_reg.mode <= pmode;
            pr_pay2_reg.neg  <= n2[NUM_W-1] ^ den[DEN_W-1];
        end
    end

    // divider chains, one per root
    logic             d1_valid [0:QW];
    logic [DEN_W-1:0] d1_rem   [0:QW];
    logic [QW-1:0]    d1_dq    [0:QW];
    logic [DEN_W-1:0] d1_den   [0:QW];
    dv_pay_t          d1_pay   [0:QW];
    logic             d2_valid [0:QW];
    logic [DEN_W-1:0] d2_rem   [0:QW];
    logic [QW-1:0]    d2_dq    [0:QW];
    logic [DEN_W-1:0] d2_den   [0:QW];
    dv_pay_t          d2_pay   [0:QW];

    assign d1_valid[0] = pr_valid_reg;
    assign d1_rem[0]   = '0;
    assign d1_dq[0]    = pr_dq1_reg;
    assign d1_den[0]   = pr_den_reg;
    assign d1_pay[0]   = pr_pay1_reg;
    assign d2_valid[0] = pr_valid_reg;
    assign d2_rem[0]   = '0;
    assign d2_dq[0]    = pr_dq2_reg;
    assign d2_den[0]   = pr_den_reg;
    assign d2_pay[0]   = pr_pay2_reg;

    for (genvar i = 0; i < QW; i++)
    begin : g_div
        qrs_div_cell #(
            .QW (QW)
        ) u_cell1 (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .valid_i (d1_valid[i]),
            .rem_i   (d1_rem[i]),
            .dq_i    (d1_dq[i]),
            .den_i   (d1_den[i]),
            .pay_i   (d1_pay[i]),
            .valid_o (d1_valid[i+1]),
            .rem_o   (d1_rem[i+1]),
            .dq_o    (d1_dq[i+1]),
            .den_o   (d1_den[i+1]),
            .pay_o   (d1_pay[i+1])
        );
        qrs_div_cell #(
            .QW (QW)
        ) u_cell2 (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .valid_i (d2_valid[i]),
            .rem_i   (d2_rem[i]),
            .dq_i    (d2_dq[i]),
            .den_i   (d2_den[i]),
            .pay_i   (d2_pay[i]),
            .valid_o (d2_valid[i+1]),
            .rem_o   (d2_rem[i+1]),
            .dq_o    (d2_dq[i+1]),
            .den_o   (d2_den[i+1]),
            .pay_o   (d2_pay[i+1])
        );
    end

    // saturation and output register
    logic [QW-1:0]     q1, q2;
    logic              sat1, sat2;
    logic [COEF_W-1:0] r1, r2;
    mode_t             omode;

    logic                    out_valid_reg;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [COEF_W-1:0]       first_reg, first_next, second_reg, second_next;
    logic                    sat_reg, sat_next;

    always_comb
    begin
        q1 = d1_dq[QW];
        q2 = d2_dq[QW];
        omode = d1_pay[QW].mode;
        if (d1_pay[QW].neg)
        begin
            sat1 = (|q1[QW-1:COEF_W]) || (q1[COEF_W-1] && (|q1[COEF_W-2:0]));
            r1   = sat1 ? {1'b1, {(COEF_W-1){1'b0}}} : COEF_W'(0) - q1[COEF_W-1:0];
        end
        else
        begin
            sat1 = |q1[QW-1:COEF_W-1];
            r1   = sat1 ? {1'b0, {(COEF_W-1){1'b1}}} : q1[COEF_W-1:0];
        end
        if (d2_pay[QW].neg)
        begin
            sat2 = (|q2[QW-1:COEF_W]) || (q2[COEF_W-1] && (|q2[COEF_W-2:0]));
            r2   = sat2 ? {1'b1, {(COEF_W-1){1'b0}}} : COEF_W'(0) - q2[COEF_W-1:0];
        end
        else
        begin
            sat2 = |q2[QW-1:COEF_W-1];
            r2   = sat2 ? {1'b0, {(COEF_W-1){1'b1}}} : q2[COEF_W-1:0];
        end
        case (omode)
            MODE_LINE, MODE_ONE:
            begin
                count_next  = CNT_W'(1);
                first_next  = r1;
                second_next = '0;
                sat_next    = sat1;
            end
            MODE_TWO:
            begin
                count_next  = CNT_W'(2);
                first_next  = r1;
                second_next = r2;
                sat_next    = sat1 | sat2;
            end
            default:
            begin
                count_next  = '0;
                first_next  = '0;
                second_next = '0;
                sat_next    = 1'b0;
            end
        endcase
    end

    assign adv     = !out_valid_reg || !root_stall;
    assign y_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= d1_valid[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            count_reg  <= count_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            sat_reg    <= sat_next;
        end
    end

    assign root_valid  = out_valid_reg;
    assign root_count  = count_reg;
    assign root_first  = first_reg;
    assign root_second = second_reg;
    assign saturated   = sat_reg;

endmodule

[rtl/qrs_checker.sv]
// port-level checks for the quadratic root solver, bound to the top level
// depends on qrs_pkg and quadratic_root_solver_top
`timescale 1ns / 1ps

module qrs_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                y_stall,
    input logic                                root_valid,
    input logic                                root_stall,
    input logic [qrs_pkg::CNT_W-1:0]           root_count,
    input logic signed [qrs_pkg::COEF_W-1:0]   root_first,
    input logic signed [qrs_pkg::COEF_W-1:0]   root_second,
    input logic                                saturated
);
    import qrs_pkg::*;

    a_no_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
        root_valid && root_count == '0 |->
            root_first == '0 && root_second == '0 && !saturated)
        else $error("no-root result carries values");

    a_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
        root_valid && root_count != CNT_W'(2) |-> root_second == '0)
        else $error("second root set without two roots");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        root_valid |-> root_count != CNT_W'(3))
        else $error("root count out of range");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        root_valid && root_stall |=> root_valid && $stable(root_first) && $stable(root_count))
        else $error("stalled result changed");

    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        y_stall |-> root_valid && root_stall)
        else $error("request stalled with free output");

endmodule

bind quadratic_root_solver_top qrs_checker u_qrs_checker (.*);
